>>> hw/rtl/posq_pkg.sv
// posq_pkg: shared item types, command and status codes for the slot queue
`timescale 1ns / 1ps

package posq_pkg;

    // command codes
    localparam logic [1:0] CMD_ENQ  = 2'd0;
    localparam logic [1:0] CMD_DEQ  = 2'd1;
    localparam logic [1:0] CMD_PEEK = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // one stored time slot, 27 bits
    typedef struct packed {
        logic [2:0] day;
        logic [4:0] sh;
        logic [5:0] sm;
        logic [4:0] eh;
        logic [5:0] em;
        logic [1:0] lvl;
    } t_slot;

    // input item
    typedef struct packed {
        logic [1:0] command;
        logic [2:0] day_code;
        logic [4:0] start_hour;
        logic [5:0] start_minute;
        logic [4:0] end_hour;
        logic [5:0] end_minute;
        logic [1:0] level;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [1:0] status;
        logic       entry_valid;
        logic [2:0] out_day;
        logic [4:0] out_start_hour;
        logic [5:0] out_start_minute;
        logic [4:0] out_end_hour;
        logic [5:0] out_end_minute;
        logic [1:0] out_level;
        logic [4:0] occupancy;
    } t_out_item;

endpackage

>>> hw/rtl/posq_mem.sv
// posq_mem: slot storage, one write port and one registered read port
`timescale 1ns / 1ps

module posq_mem #(
    parameter int QUEUE_DEPTH = 16,
    parameter int AW          = 4
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  posq_pkg::t_slot       i_wdata,
    input  logic [AW-1:0]         i_raddr,
    output posq_pkg::t_slot       o_rdata
);

    posq_pkg::t_slot r_mem [QUEUE_DEPTH];
    posq_pkg::t_slot r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/posq_ctrl.sv
// posq_ctrl: command sequencer, ring pointers and sorted insert over the slot memory
`timescale 1ns / 1ps

module posq_ctrl #(
    parameter int QUEUE_DEPTH = 16,
    parameter int AW          = 4,
    parameter int CW          = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command side
    input  logic                  i_in_valid,
    input  posq_pkg::t_in_item    i_in_item,
    output logic                  o_busy,
    // result side
    output logic                  o_res_valid,
    output posq_pkg::t_out_item   o_res,
    input  logic                  i_res_taken,
    // memory
    output logic                  o_mem_we,
    output logic [AW-1:0]         o_mem_waddr,
    output posq_pkg::t_slot       o_mem_wdata,
    output logic [AW-1:0]         o_mem_raddr,
    input  posq_pkg::t_slot       i_mem_rdata
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HEAD = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_PUT  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [AW:0] DEPTH_W = (AW+1)'(QUEUE_DEPTH);

    logic [2:0]            r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_head,  n_head;
    logic [AW-1:0]         r_idx,   n_idx;
    logic [1:0]            r_cmd,   n_cmd;
    posq_pkg::t_slot       r_entry, n_entry;
    posq_pkg::t_out_item   r_res,   n_res;

    logic                  in_accept;
    logic                  is_full;
    logic                  is_empty;
    logic [AW-1:0]         count_lo;
    logic [AW-1:0]         head_m1;
    posq_pkg::t_slot       in_slot;
    posq_pkg::t_out_item   idle_res;

    // logical position to ring address
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [AW-1:0] lidx);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, lidx};
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    // status and helpers
    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign o_busy    = (r_state != S_IDLE);
    assign is_full   = (r_count == CW'(QUEUE_DEPTH));
    assign is_empty  = (r_count == '0);
    assign count_lo  = r_count[AW-1:0];
    assign head_m1   = (r_head == '0) ? AW'(QUEUE_DEPTH - 1) : r_head - 1'b1;

    // incoming item as a slot
    always_comb begin
        in_slot.day = i_in_item.day_code;
        in_slot.sh  = i_in_item.start_hour;
        in_slot.sm  = i_in_item.start_minute;
        in_slot.eh  = i_in_item.end_hour;
        in_slot.em  = i_in_item.end_minute;
        in_slot.lvl = i_in_item.level;
        idle_res        = '0;
        idle_res.status = posq_pkg::ST_OK;
    end

    // sequencer: head read, tail-down shift scan, single insert write
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_head      = r_head;
        n_idx       = r_idx;
        n_cmd       = r_cmd;
        n_entry     = r_entry;
        n_res       = r_res;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_head;
        o_mem_wdata = r_entry;
        o_mem_raddr = r_head;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_cmd   = i_in_item.command;
                    n_entry = in_slot;
                    n_res   = idle_res;
                    case (i_in_item.command) inside
                        posq_pkg::CMD_ENQ: begin
                            if (is_full) begin
                                n_res.status = posq_pkg::ST_FULL;
                                n_state      = S_OUT;
                            end else if (is_empty) begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = r_head;
                                o_mem_wdata = in_slot;
                                n_count     = r_count + 1'b1;
                                n_state     = S_OUT;
                            end else begin
                                n_state = S_HEAD;
                            end
                        end
                        posq_pkg::CMD_DEQ, posq_pkg::CMD_PEEK: begin
                            if (is_empty) begin
                                n_res.status = posq_pkg::ST_EMPTY;
                                n_state      = S_OUT;
                            end else begin
                                n_state = S_HEAD;
                            end
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_HEAD: begin
                if (r_cmd == posq_pkg::CMD_ENQ) begin
                    if (r_entry.lvl <= i_mem_rdata.lvl) begin
                        // goes in front: move the head back one place
                        o_mem_we    = 1'b1;
                        o_mem_waddr = head_m1;
                        n_head      = head_m1;
                        n_count     = r_count + 1'b1;
                        n_state     = S_OUT;
                    end else if (r_count == CW'(1)) begin
                        o_mem_we    = 1'b1;
                        o_mem_waddr = f_phys(r_head, AW'(1));
                        n_count     = r_count + 1'b1;
                        n_state     = S_OUT;
                    end else begin
                        // start at the tail, fetch the last entry
                        n_idx       = count_lo;
                        o_mem_raddr = f_phys(r_head, count_lo - 1'b1);
                        n_state     = S_SCAN;
                    end
                end else begin
                    n_res.entry_valid      = 1'b1;
                    n_res.out_day          = i_mem_rdata.day;
                    n_res.out_start_hour   = i_mem_rdata.sh;
                    n_res.out_start_minute = i_mem_rdata.sm;
                    n_res.out_end_hour     = i_mem_rdata.eh;
                    n_res.out_end_minute   = i_mem_rdata.em;
                    n_res.out_level        = i_mem_rdata.lvl;
                    if (r_cmd == posq_pkg::CMD_DEQ) begin
                        n_head  = f_phys(r_head, AW'(1));
                        n_count = r_count - 1'b1;
                    end
                    n_state = S_OUT;
                end
            end
            S_SCAN: begin
                // data holds position idx-1; write lands at idx, read goes to idx-2
                o_mem_we    = 1'b1;
                o_mem_waddr = f_phys(r_head, r_idx);
                if (i_mem_rdata.lvl > r_entry.lvl) begin
                    o_mem_wdata = i_mem_rdata;
                    n_idx       = r_idx - 1'b1;
                    o_mem_raddr = f_phys(r_head, r_idx - 1'b1 - 1'b1);
                    if (r_idx == AW'(2)) begin
                        n_state = S_PUT;
                    end
                end else begin
                    o_mem_wdata = r_entry;
                    n_count     = r_count + 1'b1;
                    n_state     = S_OUT;
                end
            end
            S_PUT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = f_phys(r_head, r_idx);
                o_mem_wdata = r_entry;
                n_count     = r_count + 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (i_res_taken) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_cmd   <= n_cmd;
        r_entry <= n_entry;
        r_res   <= n_res;
    end

    // result with occupancy after the command
    always_comb begin
        o_res           = r_res;
        o_res.occupancy = 5'(r_count);
    end
    assign o_res_valid = (r_state == S_OUT);

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx >= AW'(2)))
        else $error("shift scan reached the head position");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_res.status == posq_pkg::ST_FULL) |-> is_full)
        else $error("full reported on a queue with room");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_res.status == posq_pkg::ST_EMPTY) |-> is_empty)
        else $error("empty reported on a queue with entries");

    a_deq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HEAD && r_cmd == posq_pkg::CMD_DEQ)
            |=> (r_count == $past(r_count) - 1'b1))
        else $error("dequeue did not drop the count by one");

endmodule

>>> hw/rtl/priority_ordered_slot_queue.sv
// priority_ordered_slot_queue: top level with sequencer, slot memory and output register
`timescale 1ns / 1ps
//
// Bounded priority queue of time slots, kept sorted by level (lower is more urgent).
// Command channel: i_in_valid / o_in_stall carry one t_in_item (enqueue, dequeue, peek).
// Result channel: o_out_valid / i_out_stall carry one t_out_item for every command.
// Entries live in a ring in one memory with a registered read port; dequeue only
// advances the head pointer, and an entry that sorts to the front moves it back.
// Path from the accepted command to the output register, by kind of command:
//   full, empty or unused command, and enqueue into an empty queue: straight to the result
//   dequeue, peek, and enqueue that lands at the front or right after the head: a head read
//   enqueue that moves tail entries up by one: head read, shift scan from the tail, insert
// The tail shift is the bound: one memory read and one write per cycle per entry moved.
// The next command is taken once the sequencer is back in idle.
// One command is in work at a time; o_in_stall is high from accept until the result
// moves into the output register, so a new command may be taken while the previous
// result still waits there. A stalled receiver holds the result steady and, once the
// next result is ready, holds the sequencer too.
// Reset empties the queue; memory contents are not cleared and are never read unwritten.

module priority_ordered_slot_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  posq_pkg::t_in_item    i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output posq_pkg::t_out_item   o_out_item
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic                  busy;
    logic                  res_valid;
    logic                  res_taken;
    posq_pkg::t_out_item   res;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    posq_pkg::t_slot       mem_wdata;
    logic [AW-1:0]         mem_raddr;
    posq_pkg::t_slot       mem_rdata;
    logic                  r_out_valid;
    posq_pkg::t_out_item   r_out_item;

    posq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_taken (res_taken),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    posq_mem #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // output register takes a result when empty or being drained
    assign res_taken = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_taken) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_taken) begin
            r_out_item <= res;
        end
    end

    assign o_in_stall  = busy;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
